// ===== hw/rtl/smd_pkg.sv =====
// shared types and constants for the sensor mask deframer
package smd_pkg;

	// framing bytes
	localparam logic [7:0] SYNC_FIRST  = 8'hFE;
	localparam logic [7:0] SYNC_SECOND = 8'hED;

	// request kinds carried in req_type
	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_TABLE = 1'b1;

	// default sizes
	localparam int DEVICE_COUNT_DEF = 8;
	localparam int SENSOR_COUNT_DEF = 8;

	// offsets register width, one signed byte per device
	localparam int CFG_W = 64;

	// input beat
	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic [2:0] table_device;
		logic [2:0] table_sensor;
		logic [6:0] note_pitch;
		logic [6:0] note_velocity;
		logic       note_holdable;
	} req_t;

	// output beat, one note event
	typedef struct packed {
		logic [2:0] channel;
		logic [6:0] pitch;
		logic [6:0] velocity;
		logic       note_on;
		logic       last;
	} evt_t;

	// one note table entry
	typedef struct packed {
		logic       holdable;
		logic [6:0] velocity;
		logic [6:0] pitch;
	} note_entry_t;

endpackage

// ===== hw/rtl/sensor_mask_deframe_to_note_events_core.sv =====
// sensor mask deframer turning sensor changes into note events
//
// Serial bytes arrive on the req channel (req_type low) and are searched for
// the sync pair FE ED; a repeated FE keeps the partial sync. The next byte is
// the device number, the one after it the sensor mask. The mask is XORed with
// the mask last stored for that device and each changed sensor below
// SENSOR_COUNT gives one event on the evt channel, lowest sensor first: a
// rising bit is a note-on whose velocity is the table velocity plus the
// device's signed offset byte from cfg_data, clamped to 0..127; a falling bit
// is a note-off only when the table entry is holdable. The final event of a
// packet carries last. A device number of DEVICE_COUNT or more still uses up
// its mask byte but the packet is dropped and the stored mask kept. Table
// write beats (req_type high) load one note entry and touch no framing state;
// every entry that a packet can hit must be written first. Throughput: a beat
// is taken every cycle and events leave at one per cycle while evt_stall is
// low; the only input stall is a beat arriving in the mask slot while the
// events of the previous packet are still being issued from the scan stage
// (a wait that grows while evt_stall holds the output), so the event rate is
// what bounds a full packet. The first event of a packet passes the scan
// stage and then the output register on its way to the evt port. The note
// table is one row per device, read in a single access when the mask byte is
// taken; the offsets register is always ready and is to be written by the
// user only while the block is idle; the block itself does not enforce this.
module sensor_mask_deframe_to_note_events_core
	import smd_pkg::*;
#(
	parameter int DEVICE_COUNT = DEVICE_COUNT_DEF,
	parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// request beats
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	// event beats
	output logic             evt_valid,
	input  logic             evt_stall,
	output evt_t             evt,
	// velocity offsets register
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int DEV_IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
	localparam int SEN_IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_DEVICE,
		PH_MASK
	} phase_t;

	// framing state
	phase_t         phase_q;
	logic [2:0]     held_dev_q;
	logic           dev_ok_q;

	// offsets register
	logic [CFG_W-1:0] offsets_q;

	// last mask per device
	logic [7:0]     prev_q [DEVICE_COUNT];

	// note table, one row per device, one lane per sensor
	note_entry_t [SENSOR_COUNT-1:0] table_mem [DEVICE_COUNT];

	// scan stage
	logic                           s1_vld;
	logic [SENSOR_COUNT-1:0]        diff_s1;
	logic [SENSOR_COUNT-1:0]        mask_s1;
	logic [2:0]                     dev_s1;
	note_entry_t [SENSOR_COUNT-1:0] row_s1;

	// output register
	logic evt_vld_q;
	evt_t evt_q;

	// handshakes
	logic req_fire;
	logic byte_fire;
	logic mask_fire;
	logic tbl_we;

	// scan logic
	logic [SENSOR_COUNT-1:0] hold_vec;
	logic [SENSOR_COUNT-1:0] qual;
	logic [SENSOR_COUNT-1:0] sel;
	logic [SENSOR_COUNT-1:0] rest;
	logic [SEN_IDX_W-1:0]    sel_idx;
	logic                    found;
	logic                    out_free;
	logic                    evt_load;
	note_entry_t             sel_entry;
	logic [7:0]              off_byte;
	logic signed [8:0]       vel_sum;
	logic [6:0]              vel_sat;
	evt_t                    evt_next;

	// a mask byte must wait for the scan stage to drain
	assign req_stall = s1_vld && (phase_q == PH_MASK);
	assign req_fire  = req_valid && !req_stall;
	assign byte_fire = req_fire && (req.req_type == REQ_BYTE);
	assign mask_fire = byte_fire && (phase_q == PH_MASK) && dev_ok_q;
	assign tbl_we    = req_fire && (req.req_type == REQ_TABLE)
		&& (int'(req.table_device) < DEVICE_COUNT)
		&& (int'(req.table_sensor) < SENSOR_COUNT);

	assign cfg_ready = 1'b1;

	// sync hunt and device capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			held_dev_q <= '0;
			dev_ok_q   <= 1'b1;
		end else if (byte_fire) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (req.data_byte == SYNC_FIRST) begin
						phase_q <= PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					if (req.data_byte == SYNC_SECOND) begin
						phase_q <= PH_DEVICE;
					end else if (req.data_byte == SYNC_FIRST) begin
						phase_q <= PH_SYNC2;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_DEVICE: begin
					held_dev_q <= req.data_byte[2:0];
					dev_ok_q   <= int'(req.data_byte) < DEVICE_COUNT;
					phase_q    <= PH_MASK;
				end
				PH_MASK: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offsets_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offsets_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DEVICE_COUNT; d++) begin
				prev_q[d] <= '0;
			end
		end else if (mask_fire) begin
			prev_q[held_dev_q[DEV_IDX_W-1:0]] <= req.data_byte;
		end
	end

	// note table: lane write, whole row read when the mask byte is taken
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			table_mem[req.table_device[DEV_IDX_W-1:0]][req.table_sensor[SEN_IDX_W-1:0]] <=
				'{holdable: req.note_holdable,
				  velocity: req.note_velocity,
				  pitch:    req.note_pitch};
		end
		if (mask_fire) begin
			row_s1 <= table_mem[held_dev_q[DEV_IDX_W-1:0]];
		end
	end

	// pick the lowest sensor that yields an event
	always_comb begin
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			hold_vec[i] = row_s1[i].holdable;
		end
		qual    = diff_s1 & (mask_s1 | hold_vec);
		sel     = qual & (~qual + SENSOR_COUNT'(1));
		rest    = qual & ~sel;
		found   = |qual;
		sel_idx = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (sel[i]) begin
				sel_idx = SEN_IDX_W'(i);
			end
		end
	end

	assign sel_entry = row_s1[sel_idx];
	assign off_byte  = offsets_q[{dev_s1, 3'b000} +: 8];
	assign vel_sum   = $signed({2'b00, sel_entry.velocity}) + $signed({off_byte[7], off_byte});

	// clamp to 0..127
	always_comb begin
		if (vel_sum[8]) begin
			vel_sat = '0;
		end else if (vel_sum[7]) begin
			vel_sat = 7'h7F;
		end else begin
			vel_sat = vel_sum[6:0];
		end
	end

	always_comb begin
		evt_next.channel  = dev_s1;
		evt_next.pitch    = sel_entry.pitch;
		evt_next.note_on  = |(sel & mask_s1);
		evt_next.velocity = evt_next.note_on ? vel_sat : 7'd0;
		evt_next.last     = !(|rest);
	end

	assign out_free = !evt_vld_q || !evt_stall;
	assign evt_load = s1_vld && found && out_free;

	// scan stage: one event per cycle while the output is free, until no change is left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else if (mask_fire) begin
			s1_vld <= 1'b1;
		end else if (s1_vld && !found) begin
			s1_vld <= 1'b0;
		end else if (evt_load && !(|rest)) begin
			s1_vld <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mask_fire) begin
			diff_s1 <= SENSOR_COUNT'(req.data_byte ^ prev_q[held_dev_q[DEV_IDX_W-1:0]]);
			mask_s1 <= SENSOR_COUNT'(req.data_byte);
			dev_s1  <= held_dev_q;
		end else if (evt_load) begin
			diff_s1 <= diff_s1 & ~sel;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_vld_q <= 1'b0;
		end else if (evt_load) begin
			evt_vld_q <= 1'b1;
		end else if (!evt_stall) begin
			evt_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_load) begin
			evt_q <= evt_next;
		end
	end

	assign evt_valid = evt_vld_q;
	assign evt       = evt_q;

`ifndef SYNTH
	// an in-range mask byte always starts a scan
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		mask_fire |=> s1_vld)
		else $error("scan stage not started after mask byte");

	// the event flagged last ends the scan
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_load && evt_next.last) |=> !s1_vld)
		else $error("scan still busy after last event");

	// the stored mask follows the taken mask byte
	a_prev_upd: assert property (@(posedge clk) disable iff (!arst_n)
		mask_fire |=> (prev_q[$past(held_dev_q[DEV_IDX_W-1:0])] == $past(req.data_byte)))
		else $error("stored mask not updated");
`endif

endmodule
